// ----- hw/rtl/pact_pkg.sv -----
// ----------------------------------------------------------------------------
// pact_pkg: shared types and constants of the position tracker
// Field widths, saturation limits, controller states and the command and
// status records that join the controller to the datapath.
// ----------------------------------------------------------------------------
package pact_pkg;

  localparam int unsigned ASSETS_DEF = 256;

  localparam int unsigned IDX_W   = 8;
  localparam int unsigned QTY_W   = 31;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned MONEY_W = 64;
  localparam int unsigned COMM_W  = 63;
  localparam int unsigned NUM_W   = 64;

  localparam int unsigned DIV_STEPS = 32;

  localparam logic FUNC_FILL = 1'b0;

  localparam logic [POS_W-1:0]          POS_MAX   = 32'h7fff_ffff;
  localparam logic signed [MONEY_W:0]   MONEY_MAX = 65'sh0_7fff_ffff_ffff_ffff;
  localparam logic signed [MONEY_W:0]   MONEY_MIN = -MONEY_MAX;
  localparam logic [COMM_W-1:0]         COMM_MAX  = {COMM_W{1'b1}};

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_MUL_COST,
    ST_MUL_PRICE,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_MUL_PNL,
    ST_UPDATE,
    ST_OUT
  } pact_state_t;

  typedef enum logic [1:0] {
    MUL_COST_MAG,
    MUL_PRICE_QTY,
    MUL_DIFF_CLOSE
  } pact_mul_sel_t;

  typedef struct packed {
    logic          clear;
    logic          load;
    logic          decide;
    logic          mul_en;
    pact_mul_sel_t mul_sel;
    logic          num_load;
    logic          div_start;
    logic          update;
    logic          out_load;
  } pact_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic fill_ok;
    logic flat;
    logic same_side;
    logic div_done;
    logic out_free;
  } pact_status_t;

endpackage

// ----- hw/rtl/pact_ctrl.sv -----
// ----------------------------------------------------------------------------
// pact_ctrl: sequencer of the position tracker
// Walks each beat through table read, then multiplies, division and table update
// as its case needs, and runs the table clearing pass after reset.
// ----------------------------------------------------------------------------
module pact_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pact_pkg::pact_status_t status,
  output pact_pkg::pact_cmd_t    cmd
);
  import pact_pkg::*;

  pact_state_t state_r;
  pact_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = !rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (!status.fill_ok) begin
          state_nxt = ST_OUT;
        end else if (status.flat) begin
          state_nxt = ST_UPDATE;
        end else if (status.same_side) begin
          state_nxt = ST_MUL_COST;
        end else begin
          state_nxt = ST_MUL_PNL;
        end
      end
      ST_MUL_COST: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_COST_MAG;
        state_nxt   = ST_MUL_PRICE;
      end
      ST_MUL_PRICE: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_PRICE_QTY;
        cmd.num_load = 1'b1;
        state_nxt    = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (status.div_done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_MUL_PNL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DIFF_CLOSE;
        state_nxt   = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- hw/rtl/pact_div.sv -----
// ----------------------------------------------------------------------------
// pact_div: radix-2 restoring divider for the weighted average cost
// Divides a 64-bit numerator by a 32-bit divisor one quotient bit per cycle.
// The quotient is known to fit 32 bits, so the upper numerator half seeds
// the remainder.
// ----------------------------------------------------------------------------
module pact_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [pact_pkg::NUM_W-1:0]        num,
  input  logic [pact_pkg::PRICE_W-1:0]      den,
  output logic                              done,
  output logic [pact_pkg::PRICE_W-1:0]      quot
);
  import pact_pkg::*;

  localparam int unsigned CW = $clog2(DIV_STEPS);

  logic              busy_r;
  logic [CW-1:0]     cnt_r;
  logic [PRICE_W-1:0] rem_r;
  logic [PRICE_W-1:0] lo_r;
  logic [PRICE_W-1:0] den_r;

  logic [PRICE_W:0]   trial;
  logic [PRICE_W:0]   diff;
  logic               ge;
  logic [PRICE_W-1:0] rem_nxt;

  assign trial   = {rem_r, lo_r[PRICE_W-1]};
  assign diff    = trial - {1'b0, den_r};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? diff[PRICE_W-1:0] : trial[PRICE_W-1:0];
  assign done    = busy_r && (cnt_r == '0);
  assign quot    = lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[NUM_W-1:PRICE_W];
      lo_r  <= num[PRICE_W-1:0];
      den_r <= den;
      cnt_r <= CW'(DIV_STEPS - 1);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= {lo_r[PRICE_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ----- hw/rtl/pact_dp.sv -----
// ----------------------------------------------------------------------------
// pact_dp: datapath of the position tracker
// Holds the position and cost tables, the shared multiplier, the divider,
// the realized and commission sums and the result register.
// ----------------------------------------------------------------------------
module pact_dp #(
  parameter int unsigned ASSETS = pact_pkg::ASSETS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pact_pkg::pact_cmd_t                 cmd,
  output pact_pkg::pact_status_t              status,
  input  logic                                in_func,
  input  logic [pact_pkg::IDX_W-1:0]          in_asset_index,
  input  logic                                in_is_buy,
  input  logic [pact_pkg::QTY_W-1:0]          in_fill_qty,
  input  logic [pact_pkg::PRICE_W-1:0]        in_fill_price,
  input  logic [pact_pkg::PRICE_W-1:0]        in_commission_fee,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic                                out_applied,
  output logic signed [pact_pkg::POS_W-1:0]   out_position_after,
  output logic [pact_pkg::PRICE_W-1:0]        out_avg_cost_after,
  output logic signed [pact_pkg::MONEY_W-1:0] out_realized_total,
  output logic [pact_pkg::COMM_W-1:0]         out_commission_total
);
  import pact_pkg::*;

  localparam int unsigned AW = (ASSETS > 1) ? $clog2(ASSETS) : 1;

  logic [POS_W-1:0]   pos_mem  [ASSETS];
  logic [PRICE_W-1:0] cost_mem [ASSETS];

  logic [AW-1:0]      clr_r;
  logic               func_r;
  logic [IDX_W-1:0]   idx_r;
  logic               buy_r;
  logic [QTY_W-1:0]   qty_r;
  logic [PRICE_W-1:0] price_r;
  logic [PRICE_W-1:0] fee_r;
  logic signed [POS_W-1:0] pos_rd_r;
  logic [PRICE_W-1:0] cost_rd_r;
  logic [NUM_W-1:0]   prod_r;
  logic [NUM_W-1:0]   num_r;
  logic signed [MONEY_W-1:0] realized_r;
  logic [COMM_W-1:0]  comm_r;
  logic               res_applied_r;
  logic signed [POS_W-1:0] res_pos_r;
  logic [PRICE_W-1:0] res_cost_r;
  logic               out_valid_r;
  logic               out_applied_r;
  logic signed [POS_W-1:0] out_pos_r;
  logic [PRICE_W-1:0] out_cost_r;
  logic signed [MONEY_W-1:0] out_real_r;
  logic [COMM_W-1:0]  out_comm_r;

  logic [AW-1:0]      addr;
  logic               idx_valid;
  logic               cur_neg;
  logic               cur_zero;
  logic [QTY_W-1:0]   mag;
  logic               same_side;
  logic [POS_W-1:0]   sq_mag;
  logic signed [POS_W-1:0] sq;
  logic signed [POS_W-1:0] np;
  logic [POS_W-1:0]   tot;
  logic [POS_W-1:0]   sat_mag;
  logic signed [POS_W-1:0] pos_same;
  logic [QTY_W-1:0]   closed_amt;
  logic               dneg;
  logic [PRICE_W-1:0] dmag;
  logic               pnl_neg;
  logic [PRICE_W-1:0] mul_a;
  logic [PRICE_W-1:0] mul_b;
  logic [NUM_W-1:0]   mul_p;
  logic [NUM_W-1:0]   div_num;
  logic               div_done;
  logic [PRICE_W-1:0] div_quot;
  logic signed [POS_W-1:0] pos_nxt;
  logic [PRICE_W-1:0] cost_nxt;
  logic signed [MONEY_W:0] pnl;
  logic signed [MONEY_W:0] rsum;
  logic signed [MONEY_W-1:0] realized_nxt;
  logic [COMM_W:0]    csum;
  logic [COMM_W-1:0]  comm_nxt;

  assign addr      = AW'(idx_r);
  assign idx_valid = 32'(idx_r) < ASSETS;
  assign cur_neg   = pos_rd_r[POS_W-1];
  assign cur_zero  = pos_rd_r == '0;
  assign mag       = QTY_W'(cur_neg ? -pos_rd_r : pos_rd_r);
  assign same_side = !cur_zero && (qty_r != '0) && (cur_neg == !buy_r);
  assign sq_mag    = {1'b0, qty_r};
  assign sq        = buy_r ? $signed(sq_mag) : -$signed(sq_mag);
  assign np        = pos_rd_r + sq;
  assign tot       = {1'b0, mag} + {1'b0, qty_r};
  assign sat_mag   = tot[POS_W-1] ? POS_MAX : tot;
  assign pos_same  = cur_neg ? -$signed(sat_mag) : $signed(sat_mag);
  assign closed_amt = (mag < qty_r) ? mag : qty_r;
  assign dneg      = price_r < cost_rd_r;
  assign dmag      = dneg ? (cost_rd_r - price_r) : (price_r - cost_rd_r);
  assign pnl_neg   = dneg ^ cur_neg;

  assign status.clear_last = clr_r == AW'(ASSETS - 1);
  assign status.fill_ok    = idx_valid && (func_r == FUNC_FILL);
  assign status.flat       = cur_zero;
  assign status.same_side  = same_side;
  assign status.div_done   = div_done;
  assign status.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    case (cmd.mul_sel)
      MUL_COST_MAG: begin
        mul_a = cost_rd_r;
        mul_b = {1'b0, mag};
      end
      MUL_PRICE_QTY: begin
        mul_a = price_r;
        mul_b = {1'b0, qty_r};
      end
      MUL_DIFF_CLOSE: begin
        mul_a = dmag;
        mul_b = {1'b0, closed_amt};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign div_num = num_r + prod_r;

  pact_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (tot),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    if (cur_zero) begin
      pos_nxt  = sq;
      cost_nxt = price_r;
    end else if (same_side) begin
      pos_nxt  = pos_same;
      cost_nxt = div_quot;
    end else begin
      pos_nxt = np;
      if (np == '0) begin
        cost_nxt = '0;
      end else if (np[POS_W-1] != cur_neg) begin
        cost_nxt = price_r;
      end else begin
        cost_nxt = cost_rd_r;
      end
    end
  end

  always_comb begin
    pnl = pnl_neg ? -$signed({1'b0, prod_r}) : $signed({1'b0, prod_r});
    if (cur_zero || same_side) begin
      pnl = '0;
    end
    rsum = {realized_r[MONEY_W-1], realized_r} + pnl;
    if (rsum > MONEY_MAX) begin
      realized_nxt = MONEY_MAX[MONEY_W-1:0];
    end else if (rsum < MONEY_MIN) begin
      realized_nxt = MONEY_MIN[MONEY_W-1:0];
    end else begin
      realized_nxt = rsum[MONEY_W-1:0];
    end
  end

  assign csum     = {1'b0, comm_r} + (COMM_W + 1)'(fee_r);
  assign comm_nxt = (csum > {1'b0, COMM_MAX}) ? COMM_MAX : csum[COMM_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      pos_mem[clr_r]  <= '0;
      cost_mem[clr_r] <= '0;
    end else if (cmd.update) begin
      pos_mem[addr]  <= pos_nxt;
      cost_mem[addr] <= cost_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_rd_r  <= pos_mem[AW'(in_asset_index)];
      cost_rd_r <= cost_mem[AW'(in_asset_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      idx_r   <= in_asset_index;
      buy_r   <= in_is_buy;
      qty_r   <= in_fill_qty;
      price_r <= in_fill_price;
      fee_r   <= in_commission_fee;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_p;
    end
    if (cmd.num_load) begin
      num_r <= prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      realized_r <= '0;
      comm_r     <= '0;
    end else if (cmd.update) begin
      realized_r <= realized_nxt;
      comm_r     <= comm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res_applied_r <= 1'b0;
      res_pos_r     <= idx_valid ? pos_rd_r : '0;
      res_cost_r    <= idx_valid ? cost_rd_r : '0;
    end else if (cmd.update) begin
      res_applied_r <= 1'b1;
      res_pos_r     <= pos_nxt;
      res_cost_r    <= cost_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_applied_r <= res_applied_r;
      out_pos_r     <= res_pos_r;
      out_cost_r    <= res_cost_r;
      out_real_r    <= realized_r;
      out_comm_r    <= comm_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_applied          = out_applied_r;
  assign out_position_after   = out_pos_r;
  assign out_avg_cost_after   = out_cost_r;
  assign out_realized_total   = out_real_r;
  assign out_commission_total = out_comm_r;

endmodule

// ----- hw/rtl/position_average_cost_tracker.sv -----
// ----------------------------------------------------------------------------
// position_average_cost_tracker: average-cost position and P&L tracker
// Applies fill reports to a per-asset position and average cost table and
// keeps running realized P&L and commission sums, both saturating.
//
// Usage: an execution report enters on the in_ channel as one beat and
// leaves exactly one result beat on the out_ channel. A beat moves when its
// valid is high and stall is low. One report is worked on at a time.
// Steps from input to result beat: a non-fill report goes from the decision
// straight to output; a fill on a flat position goes through the table
// update; a fill against the position through the P&L multiply and the
// update; a fill that adds to it through two multiplies, the 32-step
// restoring divider of the weighted average cost and the update. The next
// input beat is taken once the result is placed in the output register.
// A result that waits under out_stall holds the block in its final step
// while the output register is full. After reset the tables are cleared one
// entry per cycle, all ASSETS entries, with in_stall high; sums zero at once.
// ----------------------------------------------------------------------------
module position_average_cost_tracker #(
  parameter int unsigned ASSETS = pact_pkg::ASSETS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic [pact_pkg::IDX_W-1:0]          in_asset_index,
  input  logic                                in_is_buy,
  input  logic [pact_pkg::QTY_W-1:0]          in_fill_qty,
  input  logic [pact_pkg::PRICE_W-1:0]        in_fill_price,
  input  logic [pact_pkg::PRICE_W-1:0]        in_commission_fee,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_applied,
  output logic signed [pact_pkg::POS_W-1:0]   out_position_after,
  output logic [pact_pkg::PRICE_W-1:0]        out_avg_cost_after,
  output logic signed [pact_pkg::MONEY_W-1:0] out_realized_total,
  output logic [pact_pkg::COMM_W-1:0]         out_commission_total
);
  import pact_pkg::*;

  pact_cmd_t    cmd;
  pact_status_t status;

  pact_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pact_dp #(
    .ASSETS (ASSETS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_func              (in_func),
    .in_asset_index       (in_asset_index),
    .in_is_buy            (in_is_buy),
    .in_fill_qty          (in_fill_qty),
    .in_fill_price        (in_fill_price),
    .in_commission_fee    (in_commission_fee),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_applied          (out_applied),
    .out_position_after   (out_position_after),
    .out_avg_cost_after   (out_avg_cost_after),
    .out_realized_total   (out_realized_total),
    .out_commission_total (out_commission_total)
  );

endmodule
